FILE: rtl/core/dlf_pkg.sv
package dlf_pkg;

  // field and datapath widths
  localparam int POS_W      = 32;
  localparam int DZ_W       = 31;
  localparam int RATE_W     = 16;
  localparam int DT_W       = 16;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int IN_DATA_W  = 2 * POS_W + DT_W;
  localparam int OUT_DATA_W = 2 * POS_W;

  // difference register: clamp error plus look-ahead needs two extra bits
  localparam int D_W      = POS_W + 2;
  // blend fraction rate * dt, unsigned Q8.24
  localparam int T_W      = RATE_W + DT_W;
  localparam int T_HALF   = T_W / 2;
  // multiplier: signed difference by a zero-extended 16-bit digit
  localparam int MB_W     = T_HALF + 1;
  localparam int P_W      = D_W + MB_W;
  localparam int ACC_W    = D_W + T_W + 1;
  localparam int RND_POS  = 24;
  localparam int SUM_W    = ACC_W - RND_POS + 1;

  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (RND_POS - 1);

  // microprogram size
  localparam int STEP_W   = 5;
  localparam int PROG_LEN = 17;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_SMOOTH   = 3'd0,
    CFG_LA_RATE  = 3'd1,
    CFG_LA_DIST  = 3'd2,
    CFG_DZ_X     = 3'd3,
    CFG_DZ_Y     = 3'd4,
    CFG_OFFSET_X = 3'd5,
    CFG_OFFSET_Y = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RATE_S,
    MUL_RATE_L,
    MUL_TS_LO,
    MUL_TS_HI,
    MUL_TL_LO,
    MUL_TL_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // difference register update
  typedef enum logic [2:0] {
    DF_HOLD,
    DF_LA,
    DF_ERR_X,
    DF_ERR_Y,
    DF_DZ_X,
    DF_DZ_Y,
    DF_ADD_LA
  } diff_op_e;

  // result register write
  typedef enum logic [2:0] {
    WR_NONE,
    WR_TGT,
    WR_TS,
    WR_TL,
    WR_LA,
    WR_FX,
    WR_FY
  } wr_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_SNAP,
    JMP_DONE
  } jump_e;

  typedef struct packed {
    mul_sel_e mul;
    acc_op_e  acc;
    diff_op_e diff;
    wr_sel_e  wr;
    jump_e    jump;
  } ctrl_word_t;

  localparam ctrl_word_t CW_IDLE = '{MUL_NONE, ACC_HOLD, DF_HOLD, WR_NONE, JMP_NEXT};

  // control store: one word per step
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = CW_IDLE;
    case (step)
      // saturated target plus offset, snap when smoothing is off
      5'd0:  cw = '{MUL_NONE,   ACC_HOLD, DF_HOLD,   WR_TGT,  JMP_SNAP};
      // blend fractions
      5'd1:  cw = '{MUL_RATE_S, ACC_HOLD, DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd2:  cw = '{MUL_RATE_L, ACC_HOLD, DF_LA,     WR_TS,   JMP_NEXT};
      5'd3:  cw = '{MUL_NONE,   ACC_HOLD, DF_HOLD,   WR_TL,   JMP_NEXT};
      // look-ahead easing
      5'd4:  cw = '{MUL_TL_LO,  ACC_HOLD, DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd5:  cw = '{MUL_TL_HI,  ACC_LOAD, DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd6:  cw = '{MUL_NONE,   ACC_ADD,  DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd7:  cw = '{MUL_NONE,   ACC_HOLD, DF_ERR_X,  WR_LA,   JMP_NEXT};
      // horizontal deadzone and follow
      5'd8:  cw = '{MUL_NONE,   ACC_HOLD, DF_DZ_X,   WR_NONE, JMP_NEXT};
      5'd9:  cw = '{MUL_NONE,   ACC_HOLD, DF_ADD_LA, WR_NONE, JMP_NEXT};
      5'd10: cw = '{MUL_TS_LO,  ACC_HOLD, DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd11: cw = '{MUL_TS_HI,  ACC_LOAD, DF_ERR_Y,  WR_NONE, JMP_NEXT};
      // vertical deadzone and follow
      5'd12: cw = '{MUL_NONE,   ACC_ADD,  DF_DZ_Y,   WR_NONE, JMP_NEXT};
      5'd13: cw = '{MUL_TS_LO,  ACC_HOLD, DF_HOLD,   WR_FX,   JMP_NEXT};
      5'd14: cw = '{MUL_TS_HI,  ACC_LOAD, DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd15: cw = '{MUL_NONE,   ACC_ADD,  DF_HOLD,   WR_NONE, JMP_NEXT};
      5'd16: cw = '{MUL_NONE,   ACC_HOLD, DF_HOLD,   WR_FY,   JMP_DONE};
      default: cw = CW_IDLE;
    endcase
    return cw;
  endfunction

  // saturate a wide signed value to the position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
      r = v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/deadzone_lookahead_follow.sv
// a transfer with the target absent goes straight to its result, a zero smoothing rate (snap)
// ends after the first step, and a full update runs a 17-step microprogram around one shared
// 34x17 multiplier; a new item is taken only once the last result has been loaded into the
// output register
// reset: follower, look-ahead, last target and all configuration registers clear to zero
module deadzone_lookahead_follow import dlf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [CFG_DW-1:0]     cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // target_x, target_y, time_step
  input  logic [0:0]            s_axis_tuser,  // target_present
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // pos_x, pos_y
  output logic [0:0]            m_axis_tuser   // target_missing
);

  state_e                  state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  ctrl_word_t              ctrl;
  logic                    in_xfer, out_load, smooth_zero;
  logic                    ov_q, ov_d;
  logic                    miss_q, out_miss_q;
  logic signed [POS_W-1:0] pos_x, pos_y, out_x_q, out_y_q;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = s_axis_tvalid && s_axis_tready;

  dlf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .load_i        (in_xfer),
    .target_x_i    ($signed(s_axis_tdata[POS_W-1:0])),
    .target_y_i    ($signed(s_axis_tdata[2*POS_W-1:POS_W])),
    .time_step_i   (s_axis_tdata[IN_DATA_W-1:2*POS_W]),
    .ctrl_i        (ctrl),
    .smooth_zero_o (smooth_zero),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = s_axis_tuser[0] ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (ctrl.jump == JMP_DONE || (ctrl.jump == JMP_SNAP && smooth_zero)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl          = CW_IDLE;
    step_d        = '0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RUN: begin
        ctrl   = ucode(step_q);
        step_d = step_q + 1'b1;
      end
      ST_DONE: out_load = !ov_q || m_axis_tready;
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      miss_q <= !s_axis_tuser[0];
    end
    if (out_load) begin
      out_x_q    <= pos_x;
      out_y_q    <= pos_y;
      out_miss_q <= miss_q;
    end
  end

  assign m_axis_tvalid   = ov_q;
  assign m_axis_tdata    = {out_y_q, out_x_q};
  assign m_axis_tuser[0] = out_miss_q;

  // an absent target skips the program
  a_absent_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !s_axis_tuser[0]) |=> (state_q == ST_DONE))
    else $error("absent target did not go straight to result");

  // the step counter never leaves the program
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q < STEP_W'(PROG_LEN)))
    else $error("step counter ran past the program");

  // zero smoothing ends after the first step
  a_snap_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == '0 && smooth_zero) |=> (state_q == ST_DONE))
    else $error("snap did not finish after the first step");

endmodule

FILE: rtl/core/dlf_datapath.sv
module dlf_datapath import dlf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_AW-1:0]       cfg_addr_i,
  input  logic [CFG_DW-1:0]       cfg_data_i,
  input  logic                    load_i,
  input  logic signed [POS_W-1:0] target_x_i,
  input  logic signed [POS_W-1:0] target_y_i,
  input  logic [DT_W-1:0]         time_step_i,
  input  ctrl_word_t              ctrl_i,
  output logic                    smooth_zero_o,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o
);

  // configuration registers
  logic [RATE_W-1:0]       smooth_q, la_rate_q;
  logic [DZ_W-1:0]         la_dist_q, dz_x_q, dz_y_q;
  logic signed [POS_W-1:0] off_x_q, off_y_q;

  // follower state
  logic signed [POS_W-1:0] fx_q, fy_q, last_x_q, last_y_q, la_q;

  // working registers
  logic signed [POS_W-1:0] tx_q, ty_q, tpx_q, tpy_q;
  logic [DT_W-1:0]         dt_q;
  logic [T_W-1:0]          ts_q, tl_q;
  logic signed [P_W-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [D_W-1:0]   d_q, d_d;

  logic signed [SUM_W-1:0] sum_x, sum_y, blend_sum;
  logic signed [POS_W-1:0] tpx_new, tpy_new, blend_a, blend_res;
  logic signed [D_W-1:0]   mul_a, want, dist_s, dzx_s, dzy_s;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod_c;

  // cut an error down to the part outside the deadzone
  function automatic logic signed [D_W-1:0] dz_cut(input logic signed [D_W-1:0] e,
                                                   input logic signed [D_W-1:0] dz);
    logic signed [D_W-1:0] r;
    if (e > dz) begin
      r = e - dz;
    end else if (e < -dz) begin
      r = e + dz;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q  <= '0;
      la_rate_q <= '0;
      la_dist_q <= '0;
      dz_x_q    <= '0;
      dz_y_q    <= '0;
      off_x_q   <= '0;
      off_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_SMOOTH:   smooth_q  <= cfg_data_i[RATE_W-1:0];
        CFG_LA_RATE:  la_rate_q <= cfg_data_i[RATE_W-1:0];
        CFG_LA_DIST:  la_dist_q <= cfg_data_i[DZ_W-1:0];
        CFG_DZ_X:     dz_x_q    <= cfg_data_i[DZ_W-1:0];
        CFG_DZ_Y:     dz_y_q    <= cfg_data_i[DZ_W-1:0];
        CFG_OFFSET_X: off_x_q   <= $signed(cfg_data_i[POS_W-1:0]);
        CFG_OFFSET_Y: off_y_q   <= $signed(cfg_data_i[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  assign smooth_zero_o = (smooth_q == '0);

  // target plus offset, saturated
  assign sum_x   = SUM_W'(tx_q) + SUM_W'(off_x_q);
  assign sum_y   = SUM_W'(ty_q) + SUM_W'(off_y_q);
  assign tpx_new = sat_pos(sum_x);
  assign tpy_new = sat_pos(sum_y);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.mul)
      MUL_RATE_S: begin
        mul_a = D_W'($signed({1'b0, smooth_q}));
        mul_b = $signed({1'b0, dt_q});
      end
      MUL_RATE_L: begin
        mul_a = D_W'($signed({1'b0, la_rate_q}));
        mul_b = $signed({1'b0, dt_q});
      end
      MUL_TS_LO: begin
        mul_a = d_q;
        mul_b = $signed({1'b0, ts_q[T_HALF-1:0]});
      end
      MUL_TS_HI: begin
        mul_a = d_q;
        mul_b = $signed({1'b0, ts_q[T_W-1:T_HALF]});
      end
      MUL_TL_LO: begin
        mul_a = d_q;
        mul_b = $signed({1'b0, tl_q[T_HALF-1:0]});
      end
      MUL_TL_HI: begin
        mul_a = d_q;
        mul_b = $signed({1'b0, tl_q[T_W-1:T_HALF]});
      end
      default: ;
    endcase
  end

  assign prod_c = P_W'(mul_a) * P_W'(mul_b);

  // blend: base plus rounded scaled difference
  always_comb begin
    case (ctrl_i.wr)
      WR_FX:   blend_a = fx_q;
      WR_FY:   blend_a = fy_q;
      default: blend_a = la_q;
    endcase
  end

  assign blend_sum = SUM_W'(blend_a) + SUM_W'($signed(acc_q[ACC_W-1:RND_POS]));
  assign blend_res = sat_pos(blend_sum);

  // difference register
  assign dist_s = D_W'($signed({1'b0, la_dist_q}));
  assign dzx_s  = D_W'($signed({1'b0, dz_x_q}));
  assign dzy_s  = D_W'($signed({1'b0, dz_y_q}));

  always_comb begin
    if (tpx_q > last_x_q) begin
      want = dist_s;
    end else if (tpx_q < last_x_q) begin
      want = -dist_s;
    end else begin
      want = '0;
    end
  end

  always_comb begin
    case (ctrl_i.diff)
      DF_LA:     d_d = want - D_W'(la_q);
      DF_ERR_X:  d_d = D_W'(tpx_q) - D_W'(fx_q);
      DF_ERR_Y:  d_d = D_W'(tpy_q) - D_W'(fy_q);
      DF_DZ_X:   d_d = dz_cut(d_q, dzx_s);
      DF_DZ_Y:   d_d = dz_cut(d_q, dzy_s);
      DF_ADD_LA: d_d = d_q + D_W'(la_q);
      default:   d_d = d_q;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tx_q <= target_x_i;
      ty_q <= target_y_i;
      dt_q <= time_step_i;
    end
    if (ctrl_i.wr == WR_TGT) begin
      tpx_q <= tpx_new;
      tpy_q <= tpy_new;
    end
    if (ctrl_i.wr == WR_TS) begin
      ts_q <= prod_q[T_W-1:0];
    end
    if (ctrl_i.wr == WR_TL) begin
      tl_q <= prod_q[T_W-1:0];
    end
    if (ctrl_i.mul != MUL_NONE) begin
      prod_q <= prod_c;
    end
    case (ctrl_i.acc)
      ACC_LOAD: acc_q <= ACC_W'(prod_q) + ACC_RND;
      ACC_ADD:  acc_q <= acc_q + (ACC_W'(prod_q) <<< T_HALF);
      default:  ;
    endcase
    d_q <= d_d;
  end

  // follower state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q     <= '0;
      fy_q     <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
      la_q     <= '0;
    end else begin
      case (ctrl_i.wr)
        WR_TGT: begin
          if (smooth_zero_o) begin
            fx_q <= tpx_new;
            fy_q <= tpy_new;
          end
        end
        WR_LA: begin
          la_q     <= blend_res;
          last_x_q <= tpx_q;
          last_y_q <= tpy_q;
        end
        WR_FX: fx_q <= blend_res;
        WR_FY: fy_q <= blend_res;
        default: ;
      endcase
    end
  end

  assign pos_x_o = fx_q;
  assign pos_y_o = fy_q;

endmodule

FILE: bench/testbench.sv
module testbench;
  import dlf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef enum logic [1:0] {
    ACT_FRAME,
    ACT_WRITE,
    ACT_DRAIN
  } action_e;

  // one entry of the stimulus plan: a frame, a register write or a pause
  typedef struct packed {
    action_e                  act;
    logic signed [POS_W-1:0]  tx;
    logic signed [POS_W-1:0]  ty;
    logic [DT_W-1:0]          dt;
    logic                     present;
    logic [CFG_AW-1:0]        addr;
    logic [CFG_DW-1:0]        data;
  } plan_step_t;

  // follower position reported for one frame
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    missing;
  } follow_t;

  // index with no register behind it
  localparam logic [CFG_AW-1:0] CFG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_WAIT       = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PCT       = 17;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_AW-1:0]     cfg_addr_i = '0;
  logic [CFG_DW-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // target_x, target_y, time_step
  logic [0:0]            s_axis_tuser = '0;   // target_present
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // pos_x, pos_y
  logic [0:0]            m_axis_tuser;        // target_missing

  deadzone_lookahead_follow i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // follower model: settings and state
  logic [RATE_W-1:0]       rate_follow = '0;
  logic [RATE_W-1:0]       rate_lead = '0;
  logic [DZ_W-1:0]         lead_dist = '0;
  logic [DZ_W-1:0]         zone_x = '0;
  logic [DZ_W-1:0]         zone_y = '0;
  logic signed [POS_W-1:0] shift_x = '0;
  logic signed [POS_W-1:0] shift_y = '0;
  logic signed [POS_W-1:0] fol_x = '0;
  logic signed [POS_W-1:0] fol_y = '0;
  logic signed [POS_W-1:0] prev_tx = '0;
  logic signed [POS_W-1:0] prev_ty = '0;
  logic signed [POS_W-1:0] lead_x = '0;

  follow_t    follow_q[$];
  plan_step_t plan_q[$];
  int         fail_n = 0;
  int         results_n = 0;
  int         frames_in = 0;
  int         pending_n = 0;
  int         quiet_n = 0;
  int         idle_n = 0;
  logic       sent_all = 1'b0;
  logic       calm;

  // no idling on either side over a stretch of the random frames
  assign calm = (frames_in >= 500) && (frames_in < 700);

  function automatic logic signed [POS_W-1:0] sat_pos_w(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (POS_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  // a + round((b - a) * t / 2^24), ties upward, then saturate
  function automatic logic signed [POS_W-1:0] ease(input wide_t a, input wide_t b,
                                                   input logic [31:0] t);
    wide_t prod;
    prod = (b - a) * wide_t'({96'b0, t});
    prod = (prod + (wide_t'(1) <<< 23)) >>> 24;
    return sat_pos_w(a + prod);
  endfunction

  function automatic wide_t clamp_zone(input wide_t self, input wide_t tgt, input wide_t dz);
    wide_t d;
    d = tgt - self;
    if (d > dz) return tgt - dz;
    if (d < -dz) return tgt + dz;
    return self;
  endfunction

  task automatic write_setting(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    case (addr)
      CFG_SMOOTH:   rate_follow = data[RATE_W-1:0];
      CFG_LA_RATE:  rate_lead = data[RATE_W-1:0];
      CFG_LA_DIST:  lead_dist = data[DZ_W-1:0];
      CFG_DZ_X:     zone_x = data[DZ_W-1:0];
      CFG_DZ_Y:     zone_y = data[DZ_W-1:0];
      CFG_OFFSET_X: shift_x = data;
      CFG_OFFSET_Y: shift_y = data;
      default: ;
    endcase
  endtask

  // advance the follower by one frame and queue the position it reports
  task automatic predict_frame(input logic signed [POS_W-1:0] tx,
                               input logic signed [POS_W-1:0] ty,
                               input logic [DT_W-1:0] dt, input logic present);
    logic signed [POS_W-1:0] aim_x;
    logic signed [POS_W-1:0] aim_y;
    logic signed [POS_W-1:0] want;
    logic [31:0]             t_follow;
    logic [31:0]             t_lead;
    wide_t                   goal_x;
    wide_t                   goal_y;
    if (present) begin
      aim_x = sat_pos_w(wide_t'(tx) + wide_t'(shift_x));
      aim_y = sat_pos_w(wide_t'(ty) + wide_t'(shift_y));
      if (rate_follow == '0) begin
        fol_x = aim_x;
        fol_y = aim_y;
      end else begin
        t_follow = 32'(rate_follow) * 32'(dt);
        t_lead   = 32'(rate_lead) * 32'(dt);
        if (aim_x > prev_tx) begin
          want = $signed({1'b0, lead_dist});
        end else if (aim_x < prev_tx) begin
          want = -$signed({1'b0, lead_dist});
        end else begin
          want = '0;
        end
        lead_x  = ease(lead_x, want, t_lead);
        prev_tx = aim_x;
        prev_ty = aim_y;
        goal_x  = clamp_zone(fol_x, aim_x, wide_t'({1'b0, zone_x})) + wide_t'(lead_x);
        goal_y  = clamp_zone(fol_y, aim_y, wide_t'({1'b0, zone_y}));
        fol_x   = ease(fol_x, goal_x, t_follow);
        fol_y   = ease(fol_y, goal_y, t_follow);
      end
    end
    follow_q.push_back('{px: fol_x, py: fol_y, missing: !present});
  endtask

  task automatic note_failure(input string what);
    if (fail_n < MAX_REPORTS) $display("%s", what);
    fail_n++;
  endtask

  // plan builders
  task automatic add_frame(input logic signed [POS_W-1:0] tx, input logic signed [POS_W-1:0] ty,
                           input logic [DT_W-1:0] dt, input logic present);
    plan_q.push_back('{act: ACT_FRAME, tx: tx, ty: ty, dt: dt, present: present,
                       addr: '0, data: '0});
  endtask

  task automatic add_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    plan_q.push_back('{act: ACT_WRITE, tx: '0, ty: '0, dt: '0, present: 1'b0,
                       addr: addr, data: data});
  endtask

  task automatic add_drain();
    plan_q.push_back('{act: ACT_DRAIN, tx: '0, ty: '0, dt: '0, present: 1'b0,
                       addr: '0, data: '0});
  endtask

  task automatic add_setup(input logic [31:0] smooth, input logic [31:0] la_rate,
                           input logic [31:0] la_dist, input logic [31:0] dz_x,
                           input logic [31:0] dz_y, input logic [31:0] off_x,
                           input logic [31:0] off_y);
    add_write(CFG_SMOOTH, smooth);
    add_write(CFG_LA_RATE, la_rate);
    add_write(CFG_LA_DIST, la_dist);
    add_write(CFG_DZ_X, dz_x);
    add_write(CFG_DZ_Y, dz_y);
    add_write(CFG_OFFSET_X, off_x);
    add_write(CFG_OFFSET_Y, off_y);
  endtask

  // a register value: a plausible one or an extreme, sometimes raw noise
  function automatic logic [31:0] pick_word(input logic [31:0] gentle);
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4, 5: return $urandom;
      default: return gentle;
    endcase
  endfunction

  task automatic add_random_setup(input logic snap);
    logic [31:0] smooth;
    smooth = snap ? 32'h0 : pick_word($urandom_range(16'h0C00, 16'h0080));
    add_setup(smooth,
              pick_word($urandom_range(16'h0C00, 16'h0080)),
              pick_word($urandom_range(32'h0020_0000)),
              pick_word($urandom_range(32'h0020_0000)),
              pick_word($urandom_range(32'h0020_0000)),
              pick_word($urandom_range(32'h0008_0000) - 32'h0004_0000),
              pick_word($urandom_range(32'h0008_0000) - 32'h0004_0000));
  endtask

  // a moving target with random content, some jumps, gaps and raw noise
  task automatic add_random_frames(input int count);
    logic signed [POS_W-1:0] walk_x;
    logic signed [POS_W-1:0] walk_y;
    logic signed [POS_W-1:0] step_x;
    logic signed [POS_W-1:0] step_y;
    logic [DT_W-1:0]         dt;
    int                      pick;
    walk_x = $urandom_range(32'h0040_0000) - 32'h0020_0000;
    walk_y = $urandom_range(32'h0040_0000) - 32'h0020_0000;
    step_x = '0;
    step_y = '0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(119) == 0) add_drain();
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        step_x = $urandom_range(32'h0006_0000) - 32'h0003_0000;
        step_y = $urandom_range(32'h0006_0000) - 32'h0003_0000;
      end
      if ($urandom_range(14) == 0) step_x = '0;
      walk_x = walk_x + step_x;
      walk_y = walk_y + step_y;
      if (pick < 4) begin
        walk_x = $urandom;
        walk_y = $urandom;
      end
      if ($urandom_range(19) == 0) begin
        dt = '0;
      end else if ($urandom_range(9) == 0) begin
        dt = DT_W'($urandom);
      end else begin
        dt = DT_W'($urandom_range(16'h0900, 16'h0200));
      end
      if (pick < 10) begin
        add_frame($urandom, $urandom, DT_W'($urandom), 1'($urandom_range(1)));
      end else begin
        add_frame(walk_x, walk_y, dt, pick >= 16);
      end
    end
  endtask

  // sender: feeds the plan, pausing until quiet before writes and drains
  always @(posedge clk_i) begin
    plan_step_t nxt;
    logic       s_v;
    logic       c_v;
    s_v = s_axis_tvalid;
    c_v = cfg_valid_i;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) s_v = 1'b0;
      if (cfg_valid_i && cfg_ready_o) c_v = 1'b0;
      // a frame taken at this edge is still in flight
      if (pending_n == 0 && !s_v && !c_v && !(s_axis_tvalid && s_axis_tready)) begin
        if (quiet_n < SETTLE_CYCLES) quiet_n++;
      end else begin
        quiet_n = 0;
      end
      if (!s_v && !c_v && plan_q.size() > 0) begin
        nxt = plan_q[0];
        case (nxt.act)
          ACT_FRAME: begin
            if (calm || $urandom_range(99) >= IDLE_PCT) begin
              s_axis_tdata <= {nxt.dt, nxt.ty, nxt.tx};
              s_axis_tuser <= nxt.present;
              s_v = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          ACT_WRITE: begin
            if (quiet_n >= SETTLE_CYCLES) begin
              cfg_addr_i <= nxt.addr;
              cfg_data_i <= nxt.data;
              c_v = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            if (quiet_n >= SETTLE_CYCLES) void'(plan_q.pop_front());
          end
        endcase
      end
      sent_all <= (plan_q.size() == 0) && !s_v && !c_v && (quiet_n >= SETTLE_CYCLES);
    end
    s_axis_tvalid <= s_v;
    cfg_valid_i   <= c_v;
  end

  // receiver: tracks every transfer, predicts and checks results
  always @(posedge clk_i) begin
    follow_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (follow_q.size() == 0) begin
          note_failure($sformatf("unexpected result: pos_x=%h pos_y=%h missing=%b",
                                 m_axis_tdata[POS_W-1:0], m_axis_tdata[2*POS_W-1:POS_W],
                                 m_axis_tuser));
        end else begin
          want = follow_q.pop_front();
          if (m_axis_tdata[POS_W-1:0] !== want.px)
            note_failure($sformatf("result %0d pos_x: expected %h, got %h", results_n,
                                   want.px, m_axis_tdata[POS_W-1:0]));
          if (m_axis_tdata[2*POS_W-1:POS_W] !== want.py)
            note_failure($sformatf("result %0d pos_y: expected %h, got %h", results_n,
                                   want.py, m_axis_tdata[2*POS_W-1:POS_W]));
          if (m_axis_tuser[0] !== want.missing)
            note_failure($sformatf("result %0d target_missing: expected %b, got %b",
                                   results_n, want.missing, m_axis_tuser[0]));
        end
        results_n++;
      end
      if (cfg_valid_i && cfg_ready_o) write_setting(cfg_addr_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frame(s_axis_tdata[POS_W-1:0], s_axis_tdata[2*POS_W-1:POS_W],
                      s_axis_tdata[IN_DATA_W-1:2*POS_W], s_axis_tuser[0]);
        frames_in <= frames_in + 1;
      end
      pending_n     <= follow_q.size();
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_n <= 0;
      end else if (idle_n + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_n <= idle_n + 1;
      end
    end
  end

  initial begin
    // absent target right after reset, then snapping with extreme targets
    add_frame(32'h0000_0000, 32'h0000_0000, 16'h1234, 1'b0);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b1);
    // target plus offset saturates on both axes
    add_setup(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'h0444, 1'b1);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'h0444, 1'b1);
    add_frame(32'h0001_0000, 32'h0001_0000, 16'h0444, 1'b0);
    // smoothing on: zero time step with rising, falling and still target
    add_setup(32'h0100, 32'h0100, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0);
    add_frame(32'h0005_0000, 32'h0003_0000, 16'h0000, 1'b1);
    add_frame(32'h0001_0000, 32'hFFFD_0000, 16'h0000, 1'b1);
    add_frame(32'h0001_0000, 32'hFFFD_0000, 16'h0000, 1'b1);
    add_frame(32'h0004_0000, 32'h0000_4000, 16'h1000, 1'b1);
    add_frame(32'hFFF0_0000, 32'h0010_0000, 16'hFFFF, 1'b1);
    add_frame(32'h1234_5678, 32'h1234_5678, 16'h0444, 1'b0);
    // extreme rates, distance and zones, with a write to the unused index
    add_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h0000_0001);
    add_write(CFG_SPARE, 32'hFFFF_FFFF);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
    add_frame(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1);
    add_frame(32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b1);
    // random phases, each under its own register setting
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: add_setup(32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF);
        3: add_setup(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h0);
        5: add_random_setup(1'b1);
        default: add_random_setup(1'b0);
      endcase
      add_random_frames(150);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the plan to run out and all results to arrive
    @(posedge clk_i);
    while (!sent_all) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    if (follow_q.size() > 0)
      note_failure($sformatf("%0d results never arrived", follow_q.size()));
    if (fail_n == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dlf_pkg.sv
rtl/core/dlf_datapath.sv
rtl/core/deadzone_lookahead_follow.sv
bench/testbench.sv
